// ===== src/bmf_pkg.sv =====
package bmf_pkg;

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int COL_BITS         = 10;
  localparam int ROW_BITS         = 12;
  localparam int GRID_WIDTH_BITS  = 11;
  localparam int GRID_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS    = 13;
  localparam int CFG_INDEX_BITS   = 2;

  // grid limits
  localparam int MIN_DIM    = 3;
  localparam int MAX_HEIGHT = 4096;

  // divide by nine
  localparam int DIVISOR    = 9;
  localparam int GUARD_BITS = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

// ===== src/bmf_line_store.sv =====
module bmf_line_store #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 16,
  parameter int ADDR_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic        [ADDR_BITS-1:0] rd_addr,
  output logic signed [DATA_BITS-1:0] rd_data,
  input  logic                        wr_en,
  input  logic        [ADDR_BITS-1:0] wr_addr,
  input  logic signed [DATA_BITS-1:0] wr_data
);

  logic signed [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bmf_div9.sv =====
module bmf_div9 #(
  parameter int SUM_BITS = 20,
  parameter int Q_BITS   = 16
) (
  input  logic signed [SUM_BITS-1:0] sum,
  output logic signed [Q_BITS-1:0]   quot
);

  import bmf_pkg::*;

  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int SHIFT      = MAG_BITS + GUARD_BITS;
  localparam int RECIP_BITS = SHIFT - 2;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(DIVISOR - 1)) / longint'(DIVISOR);
  localparam int PROD_BITS  = MAG_BITS + RECIP_BITS;

  logic                  neg;
  logic [MAG_BITS-1:0]   mag;
  logic [PROD_BITS-1:0]  prod;
  logic [Q_BITS-1:0]     qmag;

  // magnitude times rounded-up reciprocal, then restore the sign
  // so the quotient truncates toward zero
  always_comb begin
    neg  = sum[SUM_BITS-1];
    mag  = neg ? MAG_BITS'(-sum) : MAG_BITS'(sum);
    prod = PROD_BITS'(mag) * PROD_BITS'(RECIP_BITS'(RECIP));
    qmag = Q_BITS'(prod >> SHIFT);
    quot = neg ? $signed(-qmag) : $signed(qmag);
  end

endmodule

// ===== src/box_mean_3x3_filter.sv =====
// 3x3 box mean over a raster stream of signed fixed-point samples. Samples
// enter one per transfer, row by row, left to right; grid_width and
// grid_height give the grid size including the one-sample border (values
// below 3 act as 3, above the limits act as the limits). For every interior
// position the block returns the sum of the nine neighbours divided by nine,
// truncated toward zero, with the position's column and row and a last flag
// on the final interior result of the grid. Border positions give no result.
// A new sample is taken every cycle while in_stall is low; a result passes
// stage a (line store read), stage b (column sum and window add) and the
// output register (multiply by the reciprocal of nine). Throughput is set by
// the single port pair of each line store, one read and one write a cycle.
// Any write to a configuration register restarts the grid at row 0, column
// 0; line store contents are kept and need no clearing after reset.
module box_mean_3x3_filter #(
  parameter int MAX_WIDTH   = bmf_pkg::MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = bmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [bmf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bmf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        mean,
  output logic [bmf_pkg::COL_BITS-1:0]         col,
  output logic [bmf_pkg::ROW_BITS-1:0]         row,
  output logic                                 last
);

  import bmf_pkg::*;

  // column counter wide enough to address every line store entry
  localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW       = $clog2(MAX_WIDTH + 1);
  localparam int CMPW     = (EW > GRID_WIDTH_BITS) ? EW : GRID_WIDTH_BITS;
  // one column sum, and the full nine-sample sum
  localparam int CSUM_BITS = SAMPLE_BITS + 2;
  localparam int SUM_BITS  = SAMPLE_BITS + 4;

  // configuration registers
  logic [GRID_WIDTH_BITS-1:0]  grid_width;
  logic [GRID_HEIGHT_BITS-1:0] grid_height;

  // effective grid limits
  logic [CMPW-1:0]             gw_ext;
  logic [CMPW-1:0]             eff_w;
  logic [CMPW-1:0]             eff_w_m1;
  logic [CW-1:0]               col_last;
  logic [GRID_HEIGHT_BITS-1:0] eff_h;
  logic [GRID_HEIGHT_BITS-1:0] eff_h_m1;
  logic [ROW_BITS-1:0]         row_last;

  // raster position of the next sample
  logic [CW-1:0]               col_cnt;
  logic [ROW_BITS-1:0]         row_cnt;
  logic [CW-1:0]               col_cnt_m1;
  logic [ROW_BITS-1:0]         row_cnt_m1;

  // handshake and stage moves
  logic in_accept;
  logic a_move;
  logic b_load;
  logic b_ready;
  logic c_ready;

  // stage a: sample registered while the line stores are read
  logic                        a_valid;
  logic signed [SAMPLE_BITS-1:0] a_sample;
  logic [CW-1:0]               a_col;
  logic                        a_emit;
  logic [COL_BITS-1:0]         a_out_col;
  logic [ROW_BITS-1:0]         a_out_row;
  logic                        a_last;
  logic signed [SAMPLE_BITS-1:0] top;
  logic signed [SAMPLE_BITS-1:0] mid;

  // window kept as the column sums of the two previous columns
  logic signed [CSUM_BITS-1:0] win_old;
  logic signed [CSUM_BITS-1:0] win_new;
  logic signed [CSUM_BITS-1:0] col_sum;

  // stage b: nine-sample sum
  logic                        b_valid;
  logic signed [SUM_BITS-1:0]  b_sum;
  logic [COL_BITS-1:0]         b_col;
  logic [ROW_BITS-1:0]         b_row;
  logic                        b_last;

  logic signed [SAMPLE_BITS-1:0] quot;

  // ---------------------------------------------------------------------
  // grid limits
  // ---------------------------------------------------------------------
  always_comb begin
    gw_ext = CMPW'(grid_width);
    if (gw_ext < CMPW'(MIN_DIM)) begin
      eff_w = CMPW'(MIN_DIM);
    end else if (gw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = gw_ext;
    end
    eff_w_m1 = eff_w - CMPW'(1);
    col_last = CW'(eff_w_m1);

    if (grid_height < GRID_HEIGHT_BITS'(MIN_DIM)) begin
      eff_h = GRID_HEIGHT_BITS'(MIN_DIM);
    end else if (grid_height > GRID_HEIGHT_BITS'(MAX_HEIGHT)) begin
      eff_h = GRID_HEIGHT_BITS'(MAX_HEIGHT);
    end else begin
      eff_h = grid_height;
    end
    eff_h_m1 = eff_h - GRID_HEIGHT_BITS'(1);
    row_last = ROW_BITS'(eff_h_m1);

    col_cnt_m1 = col_cnt - CW'(1);
    row_cnt_m1 = row_cnt - ROW_BITS'(1);
  end

  // ---------------------------------------------------------------------
  // flow control: each stage moves when the one after it has room
  // ---------------------------------------------------------------------
  assign c_ready   = !out_valid || !out_stall;
  assign b_ready   = !b_valid || c_ready;
  assign in_stall  = a_valid && !b_ready;
  assign in_accept = in_valid && !in_stall;
  assign a_move    = a_valid && b_ready;
  assign b_load    = b_valid && c_ready;

  // ---------------------------------------------------------------------
  // configuration and raster counters
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_BITS'(MAX_WIDTH_DEF);
      grid_height <= GRID_HEIGHT_BITS'(MAX_HEIGHT);
      col_cnt     <= '0;
      row_cnt     <= '0;
    end else if (cfg_write &&
                 (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT)) begin
      // any register write restarts the grid
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data[GRID_WIDTH_BITS-1:0];
        REG_GRID_HEIGHT: grid_height <= cfg_data[GRID_HEIGHT_BITS-1:0];
        default: begin
        end
      endcase
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_accept) begin
      if (col_cnt == col_last) begin
        col_cnt <= '0;
        row_cnt <= (row_cnt == row_last) ? '0 : row_cnt + ROW_BITS'(1);
      end else begin
        col_cnt <= col_cnt + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // line stores: upper holds row r-2, lower holds row r-1
  // ---------------------------------------------------------------------
  bmf_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (SAMPLE_BITS),
    .ADDR_BITS (CW)
  ) u_upper (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_cnt),
    .rd_data (top),
    .wr_en   (a_move),
    .wr_addr (a_col),
    .wr_data (mid)
  );

  bmf_line_store #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (SAMPLE_BITS),
    .ADDR_BITS (CW)
  ) u_lower (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_cnt),
    .rd_data (mid),
    .wr_en   (a_move),
    .wr_addr (a_col),
    .wr_data (a_sample)
  );

  // ---------------------------------------------------------------------
  // stage a
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_accept) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_sample  <= sample;
      a_col     <= col_cnt;
      // window centred one row up and one column left
      a_emit    <= (row_cnt >= ROW_BITS'(2)) && (col_cnt >= CW'(2));
      a_out_col <= COL_BITS'(col_cnt_m1);
      a_out_row <= row_cnt_m1;
      a_last    <= (row_cnt == row_last) && (col_cnt == col_last);
    end
  end

  // ---------------------------------------------------------------------
  // stage b: column sum plus the two stored column sums
  // ---------------------------------------------------------------------
  assign col_sum = CSUM_BITS'(top) + CSUM_BITS'(mid) + CSUM_BITS'(a_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_old <= '0;
      win_new <= '0;
    end else if (cfg_write &&
                 (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT)) begin
      win_old <= '0;
      win_new <= '0;
    end else if (a_move) begin
      win_old <= win_new;
      win_new <= col_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_move) begin
      b_valid <= a_emit;
    end else if (b_load) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_sum  <= SUM_BITS'(col_sum) + SUM_BITS'(win_new) + SUM_BITS'(win_old);
      b_col  <= a_out_col;
      b_row  <= a_out_row;
      b_last <= a_last;
    end
  end

  // ---------------------------------------------------------------------
  // stage c: divide by nine into the output register
  // ---------------------------------------------------------------------
  bmf_div9 #(
    .SUM_BITS (SUM_BITS),
    .Q_BITS   (SAMPLE_BITS)
  ) u_div9 (
    .sum  (b_sum),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= 1'b1;
    end else if (c_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      mean <= quot;
      col  <= b_col;
      row  <= b_row;
      last <= b_last;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= col_last && row_cnt <= row_last)
    else $error("raster counter beyond grid");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    in_accept && col_cnt == col_last |=> col_cnt == '0)
    else $error("column counter did not wrap at end of row");

  a_out_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> col != '0 && row != '0)
    else $error("result on a border position");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_valid))
    else $error("result without a pending sum");

endmodule
